>>> sv/assert_macros.svh
// assertion helpers, clocked on i_clk and held off while i_rst_n is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// implication: antecedent on one edge, consequent on the next edge
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

>>> sv/tsv_pkg.sv
`timescale 1ns / 1ps
package tsv_pkg;

    typedef logic [7:0] t_byte;

    localparam int TSV_NUMBER_DIGITS = 6;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_SQUEEZE_BLANK    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NUMBER_MODE      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SHOW_ENDS        = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SHOW_TABS        = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SHOW_NONPRINTING = 3'd4;

    localparam logic [1:0] NUM_NONE     = 2'd0;
    localparam logic [1:0] NUM_ALL      = 2'd1;
    localparam logic [1:0] NUM_NONBLANK = 2'd2;

    localparam t_byte CH_NEWLINE = 8'h0A;
    localparam t_byte CH_TAB     = 8'h09;
    localparam t_byte CH_DOLLAR  = 8'h24;
    localparam t_byte CH_CARET   = 8'h5E;
    localparam t_byte CH_QUEST   = 8'h3F;
    localparam t_byte CH_SPACE   = 8'h20;
    localparam t_byte CH_ZERO    = 8'h30;
    localparam t_byte CH_DEL     = 8'h7F;
    localparam t_byte CTRL_MAX   = 8'd31;
    localparam t_byte CARET_OFS  = 8'd64;

endpackage

>>> sv/tsv_in_if.sv
`timescale 1ns / 1ps
interface tsv_in_if import tsv_pkg::*;;
    logic  valid;
    logic  ready;
    t_byte in_byte;
    logic  new_file;

    modport source (output valid, output in_byte, output new_file, input ready);
    modport sink (input valid, input in_byte, input new_file, output ready);
endinterface

>>> sv/tsv_out_if.sv
`timescale 1ns / 1ps
interface tsv_out_if import tsv_pkg::*;;
    logic  valid;
    logic  ready;
    t_byte out_byte;
    logic  last_of_run;

    modport source (output valid, output out_byte, output last_of_run, input ready);
    modport sink (input valid, input out_byte, input last_of_run, output ready);
endinterface

>>> sv/text_stream_visualizer.sv
// latency: the first output beat is valid in the cycle after the input beat is accepted
// throughput: an input item yields 0 to NUMBER_DIGITS+3 output beats, one per cycle while
// o_out.ready is high; the next item is taken on the cycle the last beat of the current run
// leaves (or at once when the run buffer is empty), so plain bytes stream at one per cycle
// reset (synchronous, active low): all options off, line count 1, at line start,
// run buffer empty
`timescale 1ns / 1ps
`include "assert_macros.svh"
module text_stream_visualizer import tsv_pkg::*; #(
    parameter int NUMBER_DIGITS = TSV_NUMBER_DIGITS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    tsv_in_if.sink                i_in,
    tsv_out_if.source             o_out
);

    localparam int MAX_RUN = NUMBER_DIGITS + 3;
    localparam int CNT_W   = $clog2(MAX_RUN + 1);
    localparam int LC_W    = 4 * NUMBER_DIGITS;

    // options
    logic       r_squeeze, r_show_ends, r_show_tabs, r_show_np;
    logic [1:0] r_num_mode;

    // line state
    logic            r_at_line_start, n_at_line_start;
    logic [LC_W-1:0] r_line_cnt, n_line_cnt;
    logic            r_blank_seen, n_blank_seen;

    // run buffer, beat 0 is on the output
    t_byte            r_buf [MAX_RUN];
    t_byte            n_buf [MAX_RUN];
    logic [CNT_W-1:0] r_cnt, n_cnt;

    logic w_out_fire, w_in_fire;

    // item datapath
    logic            w_eff_als, w_eff_blank, w_squeezed, w_num, w_has_mid;
    logic [LC_W-1:0] w_eff_cnt, w_inc_cnt;
    t_byte           w_c, w_conv, w_mid;
    logic [3:0]      w_dig [NUMBER_DIGITS];
    logic            w_nz_from [NUMBER_DIGITS];

    assign w_out_fire = o_out.valid && o_out.ready;
    assign i_in.ready = (r_cnt == '0) || (w_out_fire && r_cnt == CNT_W'(1));
    assign w_in_fire  = i_in.valid && i_in.ready;

    assign o_out.valid       = (r_cnt != '0);
    assign o_out.out_byte    = r_buf[0];
    assign o_out.last_of_run = (r_cnt == CNT_W'(1));

    always_comb begin
        logic v_run;
        logic v_carry;
        int   k;

        k           = 0;
        w_c         = i_in.in_byte;
        w_eff_als   = i_in.new_file ? 1'b1 : r_at_line_start;
        w_eff_cnt   = i_in.new_file ? LC_W'(1) : r_line_cnt;
        w_eff_blank = i_in.new_file ? 1'b0 : r_blank_seen;

        // blank line squeezing
        w_squeezed   = 1'b0;
        n_blank_seen = w_eff_blank;
        if (r_squeeze) begin
            if (w_eff_als && w_c == CH_NEWLINE) begin
                w_squeezed   = w_eff_blank;
                n_blank_seen = 1'b1;
            end else begin
                n_blank_seen = 1'b0;
            end
        end

        w_num = w_eff_als && !w_squeezed &&
                (r_num_mode == NUM_ALL || (r_num_mode == NUM_NONBLANK && w_c != CH_NEWLINE));

        // digits and leading-zero blanking from the top digit down
        v_run = 1'b0;
        for (int i = NUMBER_DIGITS - 1; i >= 0; i--) begin
            w_dig[i]     = w_eff_cnt[4*i +: 4];
            v_run        = v_run || (w_dig[i] != 4'd0);
            w_nz_from[i] = v_run;
        end

        // bcd increment, saturating at all nines
        v_carry = 1'b1;
        for (int i = 0; i < NUMBER_DIGITS; i++) begin
            if (v_carry)
                w_inc_cnt[4*i +: 4] = (w_dig[i] == 4'd9) ? 4'd0 : w_dig[i] + 4'd1;
            else
                w_inc_cnt[4*i +: 4] = w_dig[i];
            v_carry = v_carry && (w_dig[i] == 4'd9);
        end
        if (v_carry)
            w_inc_cnt = w_eff_cnt;

        // the marker byte ahead of the character: '$' for newline, '^' for caret forms
        w_has_mid = 1'b0;
        w_mid     = CH_CARET;
        w_conv    = w_c;
        if (r_show_ends && w_c == CH_NEWLINE) begin
            w_has_mid = 1'b1;
            w_mid     = CH_DOLLAR;
        end else if (r_show_tabs && w_c == CH_TAB) begin
            w_has_mid = 1'b1;
            w_conv    = w_c + CARET_OFS;
        end else if (r_show_np && w_c != CH_NEWLINE && w_c != CH_TAB) begin
            if (w_c <= CTRL_MAX) begin
                w_has_mid = 1'b1;
                w_conv    = w_c + CARET_OFS;
            end else if (w_c == CH_DEL) begin
                w_has_mid = 1'b1;
                w_conv    = CH_QUEST;
            end
        end

        n_at_line_start = r_at_line_start;
        n_line_cnt      = r_line_cnt;
        n_cnt           = r_cnt;
        for (int i = 0; i < MAX_RUN; i++)
            n_buf[i] = r_buf[(i < MAX_RUN - 1) ? i + 1 : i];

        if (w_in_fire) begin
            n_at_line_start = w_squeezed ? 1'b1 : (w_c == CH_NEWLINE);
            n_line_cnt      = w_num ? w_inc_cnt : w_eff_cnt;
            if (w_squeezed)
                n_cnt = '0;
            else
                n_cnt = CNT_W'(w_num ? NUMBER_DIGITS + 1 : 0) + CNT_W'(w_has_mid)
                      + CNT_W'(1);
            for (int i = 0; i < MAX_RUN; i++) begin
                k = i - (w_num ? NUMBER_DIGITS + 1 : 0);
                if (w_num && i < NUMBER_DIGITS) begin
                    if (w_nz_from[NUMBER_DIGITS-1-i] || i == NUMBER_DIGITS - 1)
                        n_buf[i] = CH_ZERO + {4'd0, w_dig[NUMBER_DIGITS-1-i]};
                    else
                        n_buf[i] = CH_SPACE;
                end else if (w_num && i == NUMBER_DIGITS) begin
                    n_buf[i] = CH_TAB;
                end else if (k == 0) begin
                    n_buf[i] = w_has_mid ? w_mid : w_conv;
                end else begin
                    n_buf[i] = w_conv;
                end
            end
        end else if (w_out_fire) begin
            n_cnt = r_cnt - CNT_W'(1);
        end else begin
            for (int i = 0; i < MAX_RUN; i++)
                n_buf[i] = r_buf[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_squeeze  <= 1'b0;
            r_num_mode <= NUM_NONE;
            r_show_ends <= 1'b0;
            r_show_tabs <= 1'b0;
            r_show_np  <= 1'b0;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                CFG_SQUEEZE_BLANK:    r_squeeze   <= i_cfg_data[0];
                CFG_NUMBER_MODE:      r_num_mode  <= i_cfg_data;
                CFG_SHOW_ENDS:        r_show_ends <= i_cfg_data[0];
                CFG_SHOW_TABS:        r_show_tabs <= i_cfg_data[0];
                CFG_SHOW_NONPRINTING: r_show_np   <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_at_line_start <= 1'b1;
            r_line_cnt      <= LC_W'(1);
            r_blank_seen    <= 1'b0;
            r_cnt           <= '0;
        end else begin
            r_at_line_start <= n_at_line_start;
            r_line_cnt      <= n_line_cnt;
            if (w_in_fire)
                r_blank_seen <= n_blank_seen;
            r_cnt           <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < MAX_RUN; i++)
            r_buf[i] <= n_buf[i];
    end

    // a non-final beat leaving drops the run length by exactly one
    `ASSERT_NEXT(a_run_shrinks, w_out_fire && !o_out.last_of_run && !w_in_fire,
        r_cnt == $past(r_cnt) - CNT_W'(1), "run length did not step down")
    // a squeezed newline leaves the block at line start with nothing to send
    `ASSERT_NEXT(a_squeeze_idle, w_in_fire && w_squeezed,
        r_at_line_start && r_cnt == '0, "squeezed line left output or state behind")
    `ASSERT_CLK(a_count_nonzero, r_line_cnt != '0, "line count reached zero")

    for (genvar g = 0; g < NUMBER_DIGITS; g++) begin : g_bcd_chk
        `ASSERT_CLK(a_digit_bcd, r_line_cnt[4*g +: 4] <= 4'd9, "line count digit not bcd")
    end

endmodule

>>> tb/sv/tb_text_stream_visualizer.sv
`timescale 1ns / 1ps
module tb_text_stream_visualizer import tsv_pkg::*;;

    localparam int          CLK_HALF     = 4;
    localparam int          DRAIN_TAIL   = 16;
    localparam int unsigned CYCLE_LIMIT  = 300000;
    localparam int          RAND_PHASES  = 6;
    localparam int          PHASE_ITEMS  = 42;
    localparam int          BCD_W        = 4 * TSV_NUMBER_DIGITS;
    // number_mode value outside the documented set, must act like no numbering
    localparam logic [1:0]  NUM_RESERVED = 2'd3;

    typedef struct packed {
        t_byte out_byte;
        logic  last_of_run;
    } t_disp_beat;

    typedef struct {
        bit                    is_cfg;
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0] val;
        t_byte                 b;
        bit                    nf;
        int                    n_typed;
        t_byte                 e0;
        t_byte                 e1;
    } t_plan_row;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_wr_en;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    tsv_in_if  in_if ();
    tsv_out_if out_if ();

    text_stream_visualizer u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_wr_en (cfg_wr_en),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_in        (in_if),
        .o_out       (out_if)
    );

    // shadow of the display options
    bit         opt_squeeze  = 1'b0;
    logic [1:0] opt_number   = NUM_NONE;
    bit         opt_ends     = 1'b0;
    bit         opt_tabs     = 1'b0;
    bit         opt_nonprint = 1'b0;

    // shadow of the line state
    bit               at_bol     = 1'b1;
    logic [BCD_W-1:0] line_bcd   = BCD_W'(1);
    bit               blank_seen = 1'b0;

    t_byte       disp_bytes [0:15];
    int          disp_n;
    t_disp_beat  expected_beats [$];
    t_plan_row   plan [$];
    int          mismatches  = 0;
    bit          idle_on     = 1'b1;
    int          stall_left  = 0;
    int unsigned cycle_count = 0;

    initial begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    function automatic void add_disp(t_byte x);
        disp_bytes[disp_n] = x;
        disp_n++;
    endfunction

    // displayed form of one input byte; advances the shadow line state
    function automatic void predict_display(t_byte b, bit nf);
        t_byte      c;
        bit         squeezed;
        bit         lead;
        bit         carry;
        logic [3:0] d;
        int         i;
        c        = b;
        squeezed = 1'b0;
        disp_n   = 0;
        if (nf) begin
            at_bol     = 1'b1;
            line_bcd   = BCD_W'(1);
            blank_seen = 1'b0;
        end
        if (opt_squeeze) begin
            if (at_bol && c == CH_NEWLINE) begin
                if (blank_seen)
                    squeezed = 1'b1;
                else
                    blank_seen = 1'b1;
            end else begin
                blank_seen = 1'b0;
            end
        end
        if (squeezed) begin
            at_bol = 1'b1;
            return;
        end
        if (at_bol && (opt_number == NUM_ALL ||
                       (opt_number == NUM_NONBLANK && c != CH_NEWLINE))) begin
            lead = 1'b1;
            for (i = TSV_NUMBER_DIGITS - 1; i >= 0; i--) begin
                d = line_bcd[4*i +: 4];
                if (d != 4'd0 || i == 0)
                    lead = 1'b0;
                add_disp(lead ? CH_SPACE : CH_ZERO + t_byte'(d));
            end
            add_disp(CH_TAB);
            // bcd increment, held at all nines
            if (line_bcd != {TSV_NUMBER_DIGITS{4'h9}}) begin
                carry = 1'b1;
                for (i = 0; i < TSV_NUMBER_DIGITS; i++) begin
                    if (carry) begin
                        if (line_bcd[4*i +: 4] == 4'h9) begin
                            line_bcd[4*i +: 4] = 4'h0;
                        end else begin
                            line_bcd[4*i +: 4] = line_bcd[4*i +: 4] + 4'h1;
                            carry = 1'b0;
                        end
                    end
                end
            end
        end
        if (opt_ends && c == CH_NEWLINE)
            add_disp(CH_DOLLAR);
        if (opt_tabs && c == CH_TAB) begin
            add_disp(CH_CARET);
            c = c + CARET_OFS;
        end
        if (opt_nonprint && c != CH_NEWLINE && c != CH_TAB) begin
            if (c <= CTRL_MAX) begin
                add_disp(CH_CARET);
                c = c + CARET_OFS;
            end else if (c == CH_DEL) begin
                add_disp(CH_CARET);
                c = CH_QUEST;
            end
        end
        add_disp(c);
        at_bol = (b == CH_NEWLINE);
    endfunction

    function automatic void push_beat(t_byte x, logic last);
        t_disp_beat beat;
        beat.out_byte    = x;
        beat.last_of_run = last;
        expected_beats.push_back(beat);
    endfunction

    task automatic report_mismatch(string what, t_byte got, t_byte want);
        $display("mismatch at %0t: %s got %02h want %02h", $time, what, got, want);
        mismatches++;
    endtask

    // called at a falling edge, returns at a falling edge
    task automatic send_byte(t_byte b, bit nf, int n_typed, t_byte e0, t_byte e1);
        int gap;
        int k;
        if (idle_on && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 12);
            in_if.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_if.valid    <= 1'b1;
        in_if.in_byte  <= b;
        in_if.new_file <= nf;
        @(posedge clk);
        while (!in_if.ready) @(posedge clk);
        predict_display(b, nf);
        if (n_typed == 1) begin
            push_beat(e0, 1'b1);
        end else if (n_typed == 2) begin
            push_beat(e0, 1'b0);
            push_beat(e1, 1'b1);
        end else begin
            for (k = 0; k < disp_n; k++)
                push_beat(disp_bytes[k], k == disp_n - 1);
        end
        @(negedge clk);
    endtask

    // sender holds off until every expected beat is out, plus a tail for
    // squeezed lines that produce nothing
    task automatic drain_results();
        in_if.valid <= 1'b0;
        while (expected_beats.size() != 0) @(negedge clk);
        repeat (DRAIN_TAIL) @(negedge clk);
    endtask

    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        case (idx)
            CFG_SQUEEZE_BLANK:    opt_squeeze  = val[0];
            CFG_NUMBER_MODE:      opt_number   = val;
            CFG_SHOW_ENDS:        opt_ends     = val[0];
            CFG_SHOW_TABS:        opt_tabs     = val[0];
            CFG_SHOW_NONPRINTING: opt_nonprint = val[0];
            default: ;
        endcase
        @(negedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    function automatic void row_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        t_plan_row r;
        r         = '{default: 0};
        r.is_cfg  = 1'b1;
        r.idx     = idx;
        r.val     = val;
        plan.push_back(r);
    endfunction

    function automatic void row_byte(t_byte b, bit nf, int n_typed, t_byte e0, t_byte e1);
        t_plan_row r;
        r         = '{default: 0};
        r.b       = b;
        r.nf      = nf;
        r.n_typed = n_typed;
        r.e0      = e0;
        r.e1      = e1;
        plan.push_back(r);
    endfunction

    function automatic t_byte pick_byte();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45)
            return t_byte'($urandom_range(8'h20, 8'h7E));
        else if (r < 70)
            return CH_NEWLINE;
        else if (r < 78)
            return CH_TAB;
        else if (r < 86)
            return t_byte'($urandom_range(0, CTRL_MAX));
        else if (r < 90)
            return CH_DEL;
        return t_byte'($urandom_range(0, 255));
    endfunction

    // receiver side: ready drops in bursts
    initial begin
        out_if.ready = 1'b0;
        forever begin
            @(negedge clk);
            if (stall_left != 0)
                stall_left--;
            else if (idle_on && $urandom_range(0, 7) == 0)
                stall_left = $urandom_range(1, 12);
            out_if.ready <= (stall_left == 0);
        end
    end

    always @(posedge clk) begin : check_beats
        t_disp_beat want;
        if (rst_n && out_if.valid && out_if.ready) begin
            if (expected_beats.size() == 0) begin
                report_mismatch("beat with nothing expected", out_if.out_byte, 8'h00);
            end else begin
                want = expected_beats.pop_front();
                if (out_if.out_byte !== want.out_byte)
                    report_mismatch("out_byte", out_if.out_byte, want.out_byte);
                if (out_if.last_of_run !== want.last_of_run)
                    report_mismatch("last_of_run", t_byte'(out_if.last_of_run),
                                    t_byte'(want.last_of_run));
            end
        end
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d beats pending",
                     cycle_count, expected_beats.size());
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial begin
        int ph;
        int k;
        rst_n          = 1'b0;
        cfg_wr_en      = 1'b0;
        cfg_index      = '0;
        cfg_data       = '0;
        in_if.valid    = 1'b0;
        in_if.in_byte  = '0;
        in_if.new_file = 1'b0;

        // all options off: bytes pass as they are
        row_byte("A",        1'b0, 1, "A",        8'h00);
        row_byte(8'h00,      1'b0, 1, 8'h00,      8'h00);
        row_byte(CH_DEL,     1'b0, 1, CH_DEL,     8'h00);
        row_byte(8'hFF,      1'b0, 1, 8'hFF,      8'h00);
        row_byte(CH_NEWLINE, 1'b0, 1, CH_NEWLINE, 8'h00);
        row_byte(CH_TAB,     1'b0, 1, CH_TAB,     8'h00);
        // caret notation; tab untouched without show_tabs, high bytes untouched
        row_cfg(CFG_SHOW_NONPRINTING, 2'd1);
        row_byte(8'h01,      1'b0, 2, CH_CARET,   "A");
        row_byte(CH_DEL,     1'b0, 2, CH_CARET,   CH_QUEST);
        row_byte(8'h80,      1'b0, 1, 8'h80,      8'h00);
        row_byte(CH_TAB,     1'b0, 1, CH_TAB,     8'h00);
        row_byte(8'h1F,      1'b0, 2, CH_CARET,   "_");
        // tab shown once as ^I even with show_nonprinting on
        row_cfg(CFG_SHOW_TABS, 2'd1);
        row_byte(CH_TAB,     1'b0, 2, CH_CARET,   "I");
        row_cfg(CFG_SHOW_ENDS, 2'd1);
        row_byte(CH_NEWLINE, 1'b0, 2, CH_DOLLAR,  CH_NEWLINE);
        // numbering of all lines, then of nonblank lines, with squeezing: extra blank lines vanish
        row_cfg(CFG_SQUEEZE_BLANK, 2'd1);
        row_cfg(CFG_NUMBER_MODE, NUM_ALL);
        row_byte("x",        1'b1, 0, 8'h00, 8'h00);
        row_byte(CH_NEWLINE, 1'b0, 0, 8'h00, 8'h00);
        row_byte(CH_NEWLINE, 1'b0, 0, 8'h00, 8'h00);
        row_byte(CH_NEWLINE, 1'b0, 0, 8'h00, 8'h00);
        row_byte(CH_NEWLINE, 1'b0, 0, 8'h00, 8'h00);
        row_byte(CH_TAB,     1'b0, 0, 8'h00, 8'h00);
        row_cfg(CFG_NUMBER_MODE, NUM_NONBLANK);
        row_byte(CH_NEWLINE, 1'b0, 0, 8'h00, 8'h00);
        row_byte(CH_NEWLINE, 1'b0, 0, 8'h00, 8'h00);
        row_byte("z",        1'b0, 0, 8'h00, 8'h00);
        // reserved number mode numbers nothing
        row_cfg(CFG_NUMBER_MODE, NUM_RESERVED);
        row_byte("q",        1'b1, 1, "q",        8'h00);
        row_byte(8'h00,      1'b0, 2, CH_CARET,   "@");

        repeat (12) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (plan[k]) begin
            if (plan[k].is_cfg) begin
                drain_results();
                cfg_write(plan[k].idx, plan[k].val);
            end else begin
                send_byte(plan[k].b, plan[k].nf, plan[k].n_typed, plan[k].e0, plan[k].e1);
            end
        end

        for (ph = 0; ph < RAND_PHASES; ph++) begin
            drain_results();
            cfg_write(CFG_SQUEEZE_BLANK,    CFG_DATA_W'($urandom_range(0, 1)));
            cfg_write(CFG_NUMBER_MODE,      CFG_DATA_W'($urandom_range(0, 3)));
            cfg_write(CFG_SHOW_ENDS,        CFG_DATA_W'($urandom_range(0, 1)));
            cfg_write(CFG_SHOW_TABS,        CFG_DATA_W'($urandom_range(0, 1)));
            cfg_write(CFG_SHOW_NONPRINTING, CFG_DATA_W'($urandom_range(0, 1)));
            if (ph == RAND_PHASES - 1)
                idle_on = 1'b0;
            for (k = 0; k < PHASE_ITEMS; k++) begin
                if (ph == 2 && k == PHASE_ITEMS / 2)
                    drain_results();
                send_byte(pick_byte(), $urandom_range(0, 39) == 0, 0, 8'h00, 8'h00);
            end
        end

        drain_results();
        if (mismatches == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

>>> sim.f
+incdir+sv
sv/tsv_pkg.sv
sv/tsv_in_if.sv
sv/tsv_out_if.sv
sv/text_stream_visualizer.sv
tb/sv/tb_text_stream_visualizer.sv
